>>> src/tri_icdf_pkg.sv
`default_nettype none
package tri_icdf_pkg;

    localparam int VALUE_W  = 32;
    localparam int SAMPLE_W = 32;
    localparam int DIFF_W   = VALUE_W + 1;
    localparam int UD_W     = SAMPLE_W + DIFF_W;
    localparam int RAD_W    = 2 * VALUE_W;
    localparam int REM_W    = VALUE_W + 2;

    localparam int IN_TDATA_W  = 3 * VALUE_W + SAMPLE_W;
    localparam int OUT_TDATA_W = VALUE_W;

    // front stages: input, u*d, branch select, partial products, product sum
    localparam int FRONT_STAGES = 5;
    localparam int SQRT_STAGES  = VALUE_W;
    localparam int NUM_STAGES   = FRONT_STAGES + SQRT_STAGES + 1;
    localparam int ST_IN   = 0;
    localparam int ST_UD   = 1;
    localparam int ST_SEL  = 2;
    localparam int ST_PP   = 3;
    localparam int ST_SUM  = 4;
    localparam int ST_OUT  = NUM_STAGES - 1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [VALUE_W-1:0] root;
        logic [RAD_W-1:0]   rad;
    } t_sq;

    // one digit of restoring square root
    function automatic t_sq sq_step(input t_sq q);
        logic [REM_W+1:0] rm;
        logic [REM_W+1:0] trial;
        t_sq              r;
        rm    = {q.rem, q.rad[RAD_W-1 -: 2]};
        trial = {2'b00, q.root, 2'b01};
        r.rad = {q.rad[RAD_W-3:0], 2'b00};
        if (rm >= trial) begin
            r.rem  = REM_W'(rm - trial);
            r.root = {q.root[VALUE_W-2:0], 1'b1};
        end else begin
            r.rem  = rm[REM_W-1:0];
            r.root = {q.root[VALUE_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/triangular_inverse_cdf_core.sv
`default_nettype none
// Channel  Dir  tdata (lowest bit up)                              tuser
// s_axis   in   low_bound, mode_value, high_bound, uniform_sample  -
// m_axis   out  sample_value                                       status
//
// One beat in per cycle while m_axis is not stalled; each beat passes through
// the input register, 4 arithmetic stages, 32 square root stages of one digit
// each, and the output register.
// Each stage holds its beat until the next stage frees; empty stages fill
// while downstream stalls, so no beat is lost or repeated.
// Synchronous active-low reset clears the valid bits only.
module triangular_inverse_cdf_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // low_bound, mode_value, high_bound, uniform_sample
    input  wire logic [tri_icdf_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // sample_value
    output logic [tri_icdf_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // status
    output logic                                       o_m_axis_tuser
);
    import tri_icdf_pkg::*;

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] adv;

    // stage data
    logic [VALUE_W-1:0]  r_lo, r_md, r_hi;
    logic [SAMPLE_W-1:0] r_u;

    logic [UD_W-1:0]     r2_ud;
    logic [DIFF_W-1:0]   r2_d, r2_a, r2_b;
    logic [VALUE_W-1:0]  r2_lo, r2_hi;
    logic                r2_inv;

    logic [UD_W-1:0]     r3_x;
    logic [DIFF_W-1:0]   r3_y;
    logic [VALUE_W-1:0]  r3_base;
    logic                r3_sub, r3_inv;

    logic [SAMPLE_W+DIFF_W-1:0]   r4_pl;
    logic [2*DIFF_W-1:0]          r4_ph;
    logic [VALUE_W-1:0]  r4_base;
    logic                r4_sub, r4_inv;

    logic [RAD_W-1:0]    r5_p;
    logic [VALUE_W-1:0]  r5_base;
    logic                r5_sub, r5_inv;

    t_sq                 r_sq   [SQRT_STAGES];
    logic [VALUE_W-1:0]  r_sbase[SQRT_STAGES];
    logic                r_ssub [SQRT_STAGES];
    logic                r_sinv [SQRT_STAGES];

    logic [VALUE_W-1:0]  r_res;
    logic                r_stat;

    logic [DIFF_W-1:0]   n_d, n_a, n_b;
    logic                n_inv, n_lower;
    logic [UD_W-1:0]     n_thr;
    t_sq                 n_sq0;
    t_sq                 n_sq   [SQRT_STAGES];

    // a stage takes a new beat when empty or when its own beat moves on
    always_comb begin
        adv[ST_OUT] = !r_v[ST_OUT] || i_m_axis_tready;
        for (int k = ST_OUT - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_s_axis_tready = adv[ST_IN];
    assign o_m_axis_tvalid = r_v[ST_OUT];
    assign o_m_axis_tdata  = r_res;
    assign o_m_axis_tuser  = r_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[ST_IN]) begin
                r_v[ST_IN] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        n_d   = {r_hi[VALUE_W-1], r_hi} - {r_lo[VALUE_W-1], r_lo};
        n_a   = {r_md[VALUE_W-1], r_md} - {r_lo[VALUE_W-1], r_lo};
        n_b   = {r_hi[VALUE_W-1], r_hi} - {r_md[VALUE_W-1], r_md};
        n_inv = ($signed(r_lo) > $signed(r_md)) || ($signed(r_md) > $signed(r_hi));
        n_thr   = {r2_a, {SAMPLE_W{1'b0}}};
        n_lower = r2_ud < n_thr;
        n_sq0.rem  = '0;
        n_sq0.root = '0;
        n_sq0.rad  = r5_p;
        n_sq[0] = sq_step(n_sq0);
        for (int k = 1; k < SQRT_STAGES; k++) begin
            n_sq[k] = sq_step(r_sq[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_IN]) begin
            r_lo <= i_s_axis_tdata[0 +: VALUE_W];
            r_md <= i_s_axis_tdata[VALUE_W +: VALUE_W];
            r_hi <= i_s_axis_tdata[2*VALUE_W +: VALUE_W];
            r_u  <= i_s_axis_tdata[3*VALUE_W +: SAMPLE_W];
        end
        if (adv[ST_UD]) begin
            r2_ud  <= r_u * n_d;
            r2_d   <= n_d;
            r2_a   <= n_a;
            r2_b   <= n_b;
            r2_lo  <= r_lo;
            r2_hi  <= r_hi;
            r2_inv <= n_inv;
        end
        if (adv[ST_SEL]) begin
            // upper branch: (1-u)*d = d*2^S - u*d
            if (n_lower) begin
                r3_x    <= r2_ud;
                r3_y    <= r2_a;
                r3_base <= r2_lo;
            end else begin
                r3_x    <= {r2_d, {SAMPLE_W{1'b0}}} - r2_ud;
                r3_y    <= r2_b;
                r3_base <= r2_hi;
            end
            r3_sub <= !n_lower;
            r3_inv <= r2_inv;
        end
        if (adv[ST_PP]) begin
            r4_pl   <= r3_x[SAMPLE_W-1:0] * r3_y;
            r4_ph   <= r3_x[UD_W-1:SAMPLE_W] * r3_y;
            r4_base <= r3_base;
            r4_sub  <= r3_sub;
            r4_inv  <= r3_inv;
        end
        if (adv[ST_SUM]) begin
            r5_p    <= RAD_W'(r4_ph + (2*DIFF_W)'(r4_pl[SAMPLE_W+DIFF_W-1:SAMPLE_W]));
            r5_base <= r4_base;
            r5_sub  <= r4_sub;
            r5_inv  <= r4_inv;
        end
        if (adv[FRONT_STAGES]) begin
            r_sq[0]    <= n_sq[0];
            r_sbase[0] <= r5_base;
            r_ssub[0]  <= r5_sub;
            r_sinv[0]  <= r5_inv;
        end
        for (int k = 1; k < SQRT_STAGES; k++) begin
            if (adv[FRONT_STAGES + k]) begin
                r_sq[k]    <= n_sq[k];
                r_sbase[k] <= r_sbase[k-1];
                r_ssub[k]  <= r_ssub[k-1];
                r_sinv[k]  <= r_sinv[k-1];
            end
        end
        if (adv[ST_OUT]) begin
            if (r_sinv[SQRT_STAGES-1]) begin
                r_res  <= '0;
                r_stat <= STATUS_INVALID;
            end else begin
                r_res  <= r_ssub[SQRT_STAGES-1]
                          ? r_sbase[SQRT_STAGES-1] - r_sq[SQRT_STAGES-1].root
                          : r_sbase[SQRT_STAGES-1] + r_sq[SQRT_STAGES-1].root;
                r_stat <= STATUS_OK;
            end
        end
    end

endmodule
`default_nettype wire

>>> test/triangular_inverse_cdf_core_tb.sv
`default_nettype none
module triangular_inverse_cdf_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tri_icdf_pkg::*;

    localparam int LATENCY     = 38;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1850;

    typedef struct {
        logic [VALUE_W-1:0]  low_bound;
        logic [VALUE_W-1:0]  mode_value;
        logic [VALUE_W-1:0]  high_bound;
        logic [SAMPLE_W-1:0] uniform_sample;
        bit                  typed;
        logic [VALUE_W-1:0]  typed_value;
        logic                typed_status;
    } t_draw;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               status;
    } t_sample;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    // low_bound, mode_value, high_bound, uniform_sample
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    // sample_value
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    // status
    logic                    o_m_axis_tuser;

    t_draw   draws[$];
    t_sample samples_due[$];
    int      n_sent   = 0;
    int      n_cycles = 0;
    int      n_errors = 0;
    int      cur      = 0;

    triangular_inverse_cdf_core u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expected sample: a bound plus or minus the exact floor square root of the scaled product, as a Q16.16 offset
    function automatic t_sample predict_sample(input t_draw t);
        longint      lo, md, hi, res;
        logic [127:0] d, a, b, ud, p, c, r;
        t_sample     s;
        lo = longint'($signed(t.low_bound));
        md = longint'($signed(t.mode_value));
        hi = longint'($signed(t.high_bound));
        if (lo > md || md > hi) begin
            s.value  = '0;
            s.status = STATUS_INVALID;
            return s;
        end
        d  = 128'(hi - lo);
        a  = 128'(md - lo);
        b  = 128'(hi - md);
        ud = 128'(t.uniform_sample) * d;
        if (ud < (a << SAMPLE_W))
            p = (ud * a) >> SAMPLE_W;
        else
            p = (((128'(1) << SAMPLE_W) - 128'(t.uniform_sample)) * d * b) >> SAMPLE_W;
        r = '0;
        for (int k = VALUE_W - 1; k >= 0; k--) begin
            c = r | (128'(1) << k);
            if (c * c <= p)
                r = c;
        end
        res = (ud < (a << SAMPLE_W)) ? lo + longint'(r) : hi - longint'(r);
        s.value  = res[VALUE_W-1:0];
        s.status = STATUS_OK;
        return s;
    endfunction

    function automatic void add_row(input logic [31:0] lo, md, hi, u, input bit typed,
                                    input logic [31:0] ev, input logic es);
        t_draw t;
        t = '{lo, md, hi, u, typed, ev, es};
        draws.push_back(t);
    endfunction

    function automatic logic [31:0] pick_u();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_random();
        logic [31:0] x, y, z, w;
        int          kind;
        kind = $urandom_range(0, 99);
        x = $urandom; y = $urandom; z = $urandom;
        if (kind < 10) begin
            // force an out-of-order pair
            if ($signed(x) <= $signed(y)) begin w = x; x = y; y = w; end
            if (x == y) x = x + 1;
            if ($urandom_range(0, 1)) add_row(x, y, y + ($urandom & 32'hFF), pick_u(), 0, 0, 0);
            else add_row(y - ($urandom & 32'hFF), x, y, pick_u(), 0, 0, 0);
            return;
        end
        if (kind < 15) begin
            add_row(x, x, x, pick_u(), 0, 0, 0);
            return;
        end
        if (kind < 45) begin
            y = x + ($urandom & 32'hFFFFF);
            z = y + ($urandom & 32'hFFFFF);
            if ($signed(y) < $signed(x) || $signed(z) < $signed(y)) begin
                x = 32'h0; y = $urandom & 32'hFFFFF; z = y + ($urandom & 32'hFFFFF);
            end
            add_row(x, y, z, pick_u(), 0, 0, 0);
            return;
        end
        if ($signed(x) > $signed(y)) begin w = x; x = y; y = w; end
        if ($signed(y) > $signed(z)) begin w = y; y = z; z = w; end
        if ($signed(x) > $signed(y)) begin w = x; x = y; y = w; end
        case ($urandom_range(0, 5))
            0: y = x;
            1: y = z;
            default: ;
        endcase
        add_row(x, y, z, pick_u(), 0, 0, 0);
    endfunction

    function automatic bit idle_now();
        if (n_cycles > 3000 && n_cycles < 6000)
            return 1'b0;
        return $urandom_range(0, 99) < 24;
    endfunction

    initial begin
        add_row(0, 0, 0, 0, 1, 0, STATUS_OK);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1,
                32'h8000_0000, STATUS_OK);
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678, 1,
                32'h7FFF_FFFF, STATUS_OK);
        add_row(32'h0001_0000, 0, 32'h0005_0000, 32'h8000_0000, 1, 0, STATUS_INVALID);
        add_row(0, 32'h0005_0000, 32'h0001_0000, 32'h8000_0000, 1, 0, STATUS_INVALID);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 0, STATUS_INVALID);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 0,
                STATUS_INVALID);
        // u of zero lands on the lower bound on either branch
        add_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000, STATUS_OK);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000, STATUS_OK);
        add_row(32'hFFFF_0000, 0, 32'h0001_0000, 0, 1, 32'hFFFF_0000, STATUS_OK);
        add_row(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_row(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000, 0, 0, 0);
        add_row(32'h0000_0000, 32'h0001_0000, 32'h0004_0000, 32'h3FFF_FFFF, 0, 0, 0);
        add_row(32'h0000_0000, 32'h0001_0000, 32'h0004_0000, 32'h4000_0000, 0, 0, 0);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 0, 0, 0);
        add_row(32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(32'hAAAA_AAAA, 32'hD555_5555, 32'h5555_5555, 32'h5555_5555, 0, 0, 0);
        add_row(32'h8000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 0, 0, 0);
        repeat (N_RANDOM) add_random();
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d samples outstanding", $time, samples_due.size());
            $display("triangular_inverse_cdf_core_tb: done, errors");
            $finish;
        end
    end

    // source side: hold the beat until taken, then advance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (draws[cur].typed)
                    samples_due.push_back('{draws[cur].typed_value, draws[cur].typed_status});
                else
                    samples_due.push_back(predict_sample(draws[cur]));
                n_sent = n_sent + 1;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (n_sent < draws.size() && !idle_now()) begin
                    cur = n_sent;
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {draws[cur].uniform_sample, draws[cur].high_bound,
                                        draws[cur].mode_value, draws[cur].low_bound};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: stall at random, compare each beat with the oldest sample due
    always @(posedge i_clk) begin
        t_sample s;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (samples_due.size() == 0) begin
                    $display("%0t: unexpected beat, actual value %h status %b",
                             $time, o_m_axis_tdata, o_m_axis_tuser);
                    n_errors++;
                end else begin
                    s = samples_due.pop_front();
                    if (o_m_axis_tdata !== s.value) begin
                        $display("%0t: sample_value expected %h actual %h",
                                 $time, s.value, o_m_axis_tdata);
                        n_errors++;
                    end
                    if (o_m_axis_tuser !== s.status) begin
                        $display("%0t: status expected %b actual %b",
                                 $time, s.status, o_m_axis_tuser);
                        n_errors++;
                    end
                end
            end
            i_m_axis_tready <= !idle_now();
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        wait (draws.size() > 0 && n_sent == draws.size());
        wait (samples_due.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0 && samples_due.size() == 0)
            $display("triangular_inverse_cdf_core_tb: done, clean");
        else
            $display("triangular_inverse_cdf_core_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
